@@ rtl/pct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants of the primitive collision test pipeline.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int NUM_STAGES      = 7;

    typedef enum logic [1:0] {
        OP_BOX_BOX        = 2'd0,
        OP_BOX_CIRCLE     = 2'd1,
        OP_CIRCLE_CIRCLE  = 2'd2,
        OP_CIRCLE_SEGMENT = 2'd3
    } op_t;

endpackage

@@ rtl/pct_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pct_datapath
// Seven-stage arithmetic of the pair test: differences, distance terms,
// squares, sums and decisions, split wide products, final compare.
// ----------------------------------------------------------------------------
module pct_datapath
    import pct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic [NUM_STAGES-1:0]         adv,
    input  logic [1:0]                    operation,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] first_u,
    input  logic signed [COORD_WIDTH-1:0] first_v,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic signed [COORD_WIDTH-1:0] second_u,
    input  logic signed [COORD_WIDTH-1:0] second_v,
    input  logic [COORD_WIDTH-2:0]        radius_one,
    input  logic [COORD_WIDTH-2:0]        radius_two,
    output logic                          hit
);

    localparam int D  = COORD_WIDTH + 4;
    localparam int SW = 2 * D + 1;
    localparam int P  = 2 * D;
    localparam int Q  = 4 * D + 1;

    // stage 0
    logic signed [D-1:0] ax, ay, au, av, bx, by, bu, bv, r1, r2;
    logic signed [D-1:0] a0_next, a1_next, a2_next;
    logic                bb_next;
    op_t                 s0_op_reg;
    logic                s0_bb_reg;
    logic signed [D-1:0] s0_a0_reg, s0_a1_reg, s0_a2_reg, s0_w_reg, s0_h_reg;
    logic signed [D-1:0] s0_abx_reg, s0_aby_reg, s0_tlx_reg, s0_tly_reg;

    // stage 1
    logic signed [D-1:0] cx, cy, m0, m1;
    op_t                 s1_op_reg;
    logic                s1_bb_reg, s1_fail_reg, s1_inner_reg, s1_zero_reg;
    logic signed [D-1:0] s1_q0_reg, s1_q1_reg, s1_q2_reg;
    logic signed [D-1:0] s1_abx_reg, s1_aby_reg, s1_tlx_reg, s1_tly_reg;

    // stage 2
    op_t                   s2_op_reg;
    logic                  s2_bb_reg, s2_fail_reg, s2_inner_reg, s2_zero_reg;
    logic signed [2*D-1:0] s2_p_reg [9];

    // stage 3
    logic signed [SW-1:0] ac2, ab2, acab, tl2, rr, acab_mag;
    logic                 small_le, pre_hit_next, big_next;
    logic                 s3_pre_reg, s3_big_reg;
    logic [P-1:0]         s3_a_reg [3];
    logic [P-1:0]         s3_b_reg [3];

    // stage 4
    logic                 s4_pre_reg, s4_big_reg;
    logic [2*D-1:0]       s4_pp_reg [3][4];

    // stage 5
    logic                 s5_pre_reg, s5_big_reg;
    logic [Q-1:0]         s5_prod_reg [3];

    // stage 6
    logic                 s6_hit_reg;

    always_comb
    begin
        ax = D'(first_x);
        ay = D'(first_y);
        au = D'(first_u);
        av = D'(first_v);
        bx = D'(second_x);
        by = D'(second_y);
        bu = D'(second_u);
        bv = D'(second_v);
        r1 = D'(radius_one);
        r2 = D'(radius_two);
        bb_next = !((ay + av < by) || (ay > by + bv) || (ax + au < bx) || (ax > bx + bu));
        case (op_t'(operation))
            OP_BOX_CIRCLE:
            begin
                a0_next = ((bx - ax) <<< 1) - au;
                a1_next = ((by - ay) <<< 1) - av;
                a2_next = r1 <<< 1;
            end
            OP_CIRCLE_CIRCLE:
            begin
                a0_next = (ax + au) - (bx + bu);
                a1_next = (ay + av) - (by + bv);
                a2_next = r1 + r2;
            end
            default:
            begin
                a0_next = ax - bx;
                a1_next = ay - by;
                a2_next = r1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_op_reg  <= op_t'(operation);
            s0_bb_reg  <= bb_next;
            s0_a0_reg  <= a0_next;
            s0_a1_reg  <= a1_next;
            s0_a2_reg  <= a2_next;
            s0_w_reg   <= au;
            s0_h_reg   <= av;
            s0_abx_reg <= bu - bx;
            s0_aby_reg <= bv - by;
            s0_tlx_reg <= bu - ax;
            s0_tly_reg <= bv - ay;
        end
    end

    always_comb
    begin
        cx = (s0_a0_reg < 0) ? -s0_a0_reg : s0_a0_reg;
        cy = (s0_a1_reg < 0) ? -s0_a1_reg : s0_a1_reg;
        m0 = cx - s0_w_reg;
        m1 = cy - s0_h_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_op_reg    <= s0_op_reg;
            s1_bb_reg    <= s0_bb_reg;
            s1_fail_reg  <= (cx > s0_w_reg + s0_a2_reg) || (cy > s0_h_reg + s0_a2_reg);
            s1_inner_reg <= (cx <= s0_w_reg) || (cy <= s0_h_reg);
            s1_zero_reg  <= (s0_abx_reg == 0) && (s0_aby_reg == 0);
            s1_q0_reg    <= (s0_op_reg == OP_BOX_CIRCLE) ? m0 : s0_a0_reg;
            s1_q1_reg    <= (s0_op_reg == OP_BOX_CIRCLE) ? m1 : s0_a1_reg;
            s1_q2_reg    <= s0_a2_reg;
            s1_abx_reg   <= s0_abx_reg;
            s1_aby_reg   <= s0_aby_reg;
            s1_tlx_reg   <= s0_tlx_reg;
            s1_tly_reg   <= s0_tly_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_op_reg    <= s1_op_reg;
            s2_bb_reg    <= s1_bb_reg;
            s2_fail_reg  <= s1_fail_reg;
            s2_inner_reg <= s1_inner_reg;
            s2_zero_reg  <= s1_zero_reg;
            s2_p_reg[0]  <= s1_q0_reg * s1_q0_reg;
            s2_p_reg[1]  <= s1_q1_reg * s1_q1_reg;
            s2_p_reg[2]  <= s1_q2_reg * s1_q2_reg;
            s2_p_reg[3]  <= s1_abx_reg * s1_abx_reg;
            s2_p_reg[4]  <= s1_aby_reg * s1_aby_reg;
            s2_p_reg[5]  <= s1_q0_reg * s1_abx_reg;
            s2_p_reg[6]  <= s1_q1_reg * s1_aby_reg;
            s2_p_reg[7]  <= s1_tlx_reg * s1_tlx_reg;
            s2_p_reg[8]  <= s1_tly_reg * s1_tly_reg;
        end
    end

    always_comb
    begin
        ac2      = SW'(s2_p_reg[0]) + SW'(s2_p_reg[1]);
        rr       = SW'(s2_p_reg[2]);
        ab2      = SW'(s2_p_reg[3]) + SW'(s2_p_reg[4]);
        acab     = SW'(s2_p_reg[5]) + SW'(s2_p_reg[6]);
        tl2      = SW'(s2_p_reg[7]) + SW'(s2_p_reg[8]);
        acab_mag = (acab < 0) ? -acab : acab;
        small_le = ac2 <= rr;
        big_next = 1'b0;
        case (s2_op_reg)
            OP_BOX_BOX:       pre_hit_next = s2_bb_reg;
            OP_BOX_CIRCLE:    pre_hit_next = !s2_fail_reg && (s2_inner_reg || small_le);
            OP_CIRCLE_CIRCLE: pre_hit_next = small_le;
            OP_CIRCLE_SEGMENT:
            begin
                if (s2_zero_reg || acab <= 0)
                begin
                    pre_hit_next = small_le;
                end
                else if (ab2 <= acab)
                begin
                    pre_hit_next = tl2 <= rr;
                end
                else
                begin
                    pre_hit_next = 1'b0;
                    big_next     = 1'b1;
                end
            end
            default:          pre_hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_pre_reg  <= pre_hit_next;
            s3_big_reg  <= big_next;
            s3_a_reg[0] <= P'(ac2);
            s3_b_reg[0] <= P'(ab2);
            s3_a_reg[1] <= P'(rr);
            s3_b_reg[1] <= P'(ab2);
            s3_a_reg[2] <= P'(acab_mag);
            s3_b_reg[2] <= P'(acab_mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_pre_reg <= s3_pre_reg;
            s4_big_reg <= s3_big_reg;
            for (int k = 0; k < 3; k++)
            begin
                s4_pp_reg[k][0] <= s3_a_reg[k][D-1:0] * s3_b_reg[k][D-1:0];
                s4_pp_reg[k][1] <= s3_a_reg[k][D-1:0] * s3_b_reg[k][P-1:D];
                s4_pp_reg[k][2] <= s3_a_reg[k][P-1:D] * s3_b_reg[k][D-1:0];
                s4_pp_reg[k][3] <= s3_a_reg[k][P-1:D] * s3_b_reg[k][P-1:D];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_pre_reg <= s4_pre_reg;
            s5_big_reg <= s4_big_reg;
            for (int k = 0; k < 3; k++)
            begin
                s5_prod_reg[k] <= (Q'(s4_pp_reg[k][3]) << (2 * D))
                                + ((Q'(s4_pp_reg[k][1]) + Q'(s4_pp_reg[k][2])) << D)
                                + Q'(s4_pp_reg[k][0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_hit_reg <= s5_big_reg ? (s5_prod_reg[0] <= s5_prod_reg[1] + s5_prod_reg[2])
                                     : s5_pre_reg;
        end
    end

    assign hit = s6_hit_reg;

endmodule

@@ rtl/primitive_collision_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_collision_test
// Throughput: one request per cycle; seven register stages, each holds when
// the stage after it is full and stalled.
// Reset: clears the stage valid bits only; no other state.
// ----------------------------------------------------------------------------
module primitive_collision_test
    import pct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] first_u,
    input  logic signed [COORD_WIDTH-1:0] first_v,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic signed [COORD_WIDTH-1:0] second_u,
    input  logic signed [COORD_WIDTH-1:0] second_v,
    input  logic [COORD_WIDTH-2:0]        radius_one,
    input  logic [COORD_WIDTH-2:0]        radius_two,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    pct_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .adv        (adv),
        .operation  (operation),
        .first_x    (first_x),
        .first_y    (first_y),
        .first_u    (first_u),
        .first_v    (first_v),
        .second_x   (second_x),
        .second_y   (second_y),
        .second_u   (second_u),
        .second_v   (second_v),
        .radius_one (radius_one),
        .radius_two (radius_two),
        .hit        (hit)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (valid_reg == '1))
    else $error("stall raised with an empty stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
    else $error("accepted request not in first stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_reg == '1) && out_stall) |-> in_stall)
    else $error("request taken into a full stalled pipeline");

endmodule
